@@ rtl/vfs_pkg.sv @@
// ----------------------------------------------------------------------------
// vfs_pkg: shared types and constants of the VOP frame splitter
// Start code patterns, frame kind codes and the frame record that the
// scanner hands to the output queue.
// ----------------------------------------------------------------------------
package vfs_pkg;

  localparam int unsigned POS_BITS_DEF = 24;
  localparam int unsigned TINC_W       = 5;
  localparam int unsigned FIELD_W      = 24;
  localparam int unsigned REFILL_W     = 3;

  localparam logic [REFILL_W-1:0] REFILL_LEN = 3'd4;

  localparam logic [31:0] VOP_START_CODE    = 32'h0000_01B6;
  localparam logic [31:0] START_PREFIX_MASK = 32'hFFFF_FF00;
  localparam logic [31:0] START_PREFIX      = 32'h0000_0100;

  localparam logic [1:0] KIND_INTRA = 2'd0;
  localparam logic [1:0] KIND_PRED  = 2'd1;
  localparam logic [1:0] KIND_BIDIR = 2'd2;

  typedef struct packed {
    logic               closes_buffer;
    logic               frame_coded;
    logic [1:0]         frame_kind;
    logic [FIELD_W-1:0] frame_size;
    logic [FIELD_W-1:0] frame_offset;
  } frame_rec_t;

  typedef struct packed {
    logic       push;
    frame_rec_t rec;
  } frame_req_t;

  // vop_coding_type: code 3 is handled as predicted
  function automatic logic [1:0] kind_map(input logic [1:0] code);
    logic [1:0] k;
    case (code)
      2'd0:    k = KIND_INTRA;
      2'd1:    k = KIND_PRED;
      2'd2:    k = KIND_BIDIR;
      default: k = KIND_PRED;
    endcase
    return k;
  endfunction

endpackage

@@ rtl/vfs_front.sv @@
// ----------------------------------------------------------------------------
// vfs_front: start code scanner and VOP header parser
// Slides the 32-bit window, walks the header eight bits per byte and
// builds a frame request when a frame closes.
// ----------------------------------------------------------------------------
module vfs_front #(
  parameter int unsigned POS_BITS = vfs_pkg::POS_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       accept_i,
  input  logic [7:0]                 data_byte_i,
  input  logic                       last_byte_i,
  input  logic [vfs_pkg::TINC_W-1:0] time_inc_bits_i,
  output vfs_pkg::frame_req_t        req_o
);
  import vfs_pkg::*;

  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_TYPE  = 3'd1;
  localparam logic [2:0] PH_MOD   = 3'd2;
  localparam logic [2:0] PH_MARK1 = 3'd3;
  localparam logic [2:0] PH_TINC  = 3'd4;
  localparam logic [2:0] PH_MARK2 = 3'd5;
  localparam logic [2:0] PH_CODED = 3'd6;
  localparam logic [2:0] PH_DONE  = 3'd7;

  typedef struct packed {
    logic [2:0]        phase;
    logic [TINC_W-1:0] cnt;
    logic [1:0]        kind;
    logic              coded;
  } hdr_t;

  function automatic hdr_t hdr_step(input hdr_t h, input logic b,
                                    input logic [TINC_W-1:0] tinc);
    hdr_t r;
    r = h;
    case (h.phase)
      PH_TYPE: begin
        r.kind = {h.kind[0], b};
        r.cnt  = h.cnt + TINC_W'(1);
        if (r.cnt == TINC_W'(2)) begin
          r.kind  = kind_map(r.kind);
          r.phase = PH_MOD;
        end
      end
      PH_MOD: begin
        if (!b) r.phase = PH_MARK1;
      end
      PH_MARK1: begin
        r.cnt   = '0;
        r.phase = (tinc == '0) ? PH_MARK2 : PH_TINC;
      end
      PH_TINC: begin
        r.cnt = h.cnt + TINC_W'(1);
        if (r.cnt == tinc) r.phase = PH_MARK2;
      end
      PH_MARK2: r.phase = PH_CODED;
      PH_CODED: begin
        r.coded = b;
        r.phase = PH_DONE;
      end
      default: r = h;
    endcase
    return r;
  endfunction

  logic [31:0]         window_q, window_d;
  logic [REFILL_W-1:0] refill_q, refill_d, refill_dec;
  logic [POS_BITS-1:0] pos_q, pos_d, start_pos, open_off_q, open_off_d;
  logic [POS_BITS-1:0] size_mid, size_end;
  logic                open_q, open_d, halted_q, halted_d;
  hdr_t                hdr_q, hdr_d, hdr_walk;
  logic                test, vop, emit_mid, emit_end;

  always_comb begin
    window_d   = {window_q[23:0], data_byte_i};
    refill_dec = (refill_q != '0) ? refill_q - REFILL_W'(1) : refill_q;

    hdr_walk = hdr_q;
    if (!halted_q && open_q && hdr_q.phase != PH_DONE) begin
      for (int k = 7; k >= 0; k--) begin
        hdr_walk = hdr_step(hdr_walk, data_byte_i[k], time_inc_bits_i);
      end
    end

    test = !halted_q && !last_byte_i && refill_dec == '0 &&
           (window_d & START_PREFIX_MASK) == START_PREFIX;
    vop  = test && window_d == VOP_START_CODE;
    start_pos = pos_q - POS_BITS'(3);
    // sizes wrap at the position width
    size_mid  = start_pos - open_off_q;
    size_end  = pos_q + POS_BITS'(1) - open_off_q;
    emit_mid  = vop && open_q && hdr_walk.phase == PH_DONE;
    emit_end  = last_byte_i && !halted_q && open_q && hdr_walk.phase == PH_DONE;

    refill_d   = test ? REFILL_LEN : refill_dec;
    pos_d      = pos_q + POS_BITS'(1);
    open_d     = open_q;
    open_off_d = open_off_q;
    halted_d   = halted_q;
    hdr_d      = hdr_walk;
    if (vop) begin
      if (open_q && hdr_walk.phase != PH_DONE) begin
        // header cut short by the next VOP: drop and stop scanning
        halted_d    = 1'b1;
        open_d      = 1'b0;
        hdr_d.phase = PH_IDLE;
      end else begin
        open_d      = 1'b1;
        open_off_d  = start_pos;
        hdr_d       = '{phase: PH_TYPE, cnt: '0, kind: '0, coded: 1'b0};
      end
    end
    if (last_byte_i) begin
      window_d   = '0;
      refill_d   = REFILL_LEN;
      pos_d      = '0;
      open_d     = 1'b0;
      open_off_d = '0;
      halted_d   = 1'b0;
      hdr_d      = '{phase: PH_IDLE, cnt: '0, kind: '0, coded: 1'b0};
    end

    req_o.push              = accept_i && (emit_mid || emit_end);
    req_o.rec.frame_offset  = FIELD_W'(open_off_q);
    req_o.rec.frame_size    = emit_end ? FIELD_W'(size_end) : FIELD_W'(size_mid);
    req_o.rec.frame_kind    = hdr_walk.kind;
    req_o.rec.frame_coded   = hdr_walk.coded;
    req_o.rec.closes_buffer = emit_end;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q   <= '0;
      refill_q   <= REFILL_LEN;
      pos_q      <= '0;
      open_q     <= 1'b0;
      open_off_q <= '0;
      halted_q   <= 1'b0;
      hdr_q      <= '{phase: PH_IDLE, cnt: '0, kind: '0, coded: 1'b0};
    end else if (accept_i) begin
      window_q   <= window_d;
      refill_q   <= refill_d;
      pos_q      <= pos_d;
      open_q     <= open_d;
      open_off_q <= open_off_d;
      halted_q   <= halted_d;
      hdr_q      <= hdr_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_o.push |-> (open_q && !halted_q))
    else $error("frame request without an open frame");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && last_byte_i) |=> (pos_q == '0 && !open_q && !halted_q))
    else $error("buffer state not cleared after last byte");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |-> !open_q)
    else $error("frame open while scan is halted");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    refill_q <= REFILL_LEN)
    else $error("refill count out of range");

endmodule

@@ rtl/vfs_queue.sv @@
// ----------------------------------------------------------------------------
// vfs_queue: two-entry frame queue and output stage
// Holds closed frames until the sink takes them.
// ----------------------------------------------------------------------------
module vfs_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  vfs_pkg::frame_req_t req_i,
  output logic                full_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output vfs_pkg::frame_rec_t out_rec_o
);
  import vfs_pkg::*;

  frame_rec_t mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q, count_d;
  logic       pop;

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = count_q != 2'd0;
  assign full_o      = count_q == 2'd2;
  assign out_rec_o   = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (req_i.push && !pop) count_d = count_q + 2'd1;
    else if (!req_i.push && pop) count_d = count_q - 2'd1;
  end

  always_ff @(posedge clk_i) begin
    if (req_i.push) mem_q[wr_ptr_q] <= req_i.rec;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (req_i.push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)        rd_ptr_q <= ~rd_ptr_q;
      count_q <= count_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.push |-> !full_o)
    else $error("push into full frame queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3)
    else $error("frame queue count out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == 2'd0 || count_q == 2'd2) |-> (wr_ptr_q == rd_ptr_q))
    else $error("queue pointers disagree with count");

endmodule

@@ rtl/vop_frame_splitter.sv @@
// ----------------------------------------------------------------------------
// vop_frame_splitter: VOP start code scanner and frame splitter
// Finds VOP start codes in a byte stream, parses each VOP header and
// reports each fully parsed frame with offset, size, kind and coded bit.
// ----------------------------------------------------------------------------
//  channel   direction  carries
//  s_axis    in         one buffer byte per request, tlast on final byte
//  m_axis    out        one frame per request, tlast if buffer end closed it
//  apb       in         register 0: time_inc_bits
//
//  One byte per cycle while the queue is not full; the scanner handles
//  window compare and eight header bits in the cycle it takes the byte.
//  A closed frame is registered in the queue before it shows on m_axis.
//  A two-entry frame queue sits between scanner and output; s_axis stalls
//  only while that queue is full.
//  Reset is asynchronous; no clearing pass is needed after it.
// ----------------------------------------------------------------------------
module vop_frame_splitter #(
  parameter int unsigned POS_BITS = vfs_pkg::POS_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,   // last_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [23:0] frame_offset, [47:24] frame_size, [49:48] frame_kind,
  // [50] frame_coded, [55:51] zero
  output logic [55:0] m_axis_tdata,
  output logic        m_axis_tlast,   // closes_buffer
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import vfs_pkg::*;

  logic              accept, full, reg_hit;
  logic [TINC_W-1:0] tinc_q;
  frame_req_t        req;
  frame_rec_t        out_rec;

  assign pready  = 1'b1;
  assign reg_hit = paddr[2] == 1'b0;
  assign prdata  = reg_hit ? 32'(tinc_q) : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tinc_q <= '0;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      tinc_q <= pwdata[TINC_W-1:0];
    end
  end

  assign s_axis_tready = !full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  vfs_front #(
    .POS_BITS(POS_BITS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .data_byte_i    (s_axis_tdata),
    .last_byte_i    (s_axis_tlast),
    .time_inc_bits_i(tinc_q),
    .req_o          (req)
  );

  vfs_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req),
    .full_o     (full),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_rec_o  (out_rec)
  );

  assign m_axis_tdata = {5'd0, out_rec.frame_coded, out_rec.frame_kind,
                         out_rec.frame_size, out_rec.frame_offset};
  assign m_axis_tlast = out_rec.closes_buffer;

endmodule
